// ===== rtl/core/tar_header_stream_parser_unit_macros.svh =====
// Assertion macros for the tar header stream parser.
`ifndef TAR_HEADER_STREAM_PARSER_UNIT_MACROS_SVH
`define TAR_HEADER_STREAM_PARSER_UNIT_MACROS_SVH

// Implication checked on every clock, off during reset.
`define THSP_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off during reset.
`define THSP_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/thsp_pkg.sv =====
// ----------------------------------------------------------------------------
// thsp_pkg
// Shared types and constants of the tar header stream parser.
// ----------------------------------------------------------------------------
package thsp_pkg;

	localparam int unsigned BLOCK_BYTES = 512;
	localparam int unsigned OFF_W       = 9;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_CONTENT = 2'd1,
		KIND_END     = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_CHECKSUM = 2'd1,
		ERR_MAGIC    = 2'd2,
		ERR_TRUNC    = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_CONTENT = 2'd1,
		PH_PAD     = 2'd2,
		PH_HALT    = 2'd3
	} phase_t;

	// result beat queued from front to back
	typedef struct packed {
		kind_t       kind;
		err_t        error_code;
		logic [35:0] entry_size;
		logic [35:0] mod_time;
		logic [23:0] owner_num;
		logic [23:0] group_num;
		logic [7:0]  link_type;
		logic        is_regular;
		logic [7:0]  data_byte;
		logic        last_of_file;
	} result_t;

	localparam int unsigned RES_W = $bits(result_t);

	function automatic logic [7:0] magic_ustar_sp(input logic [2:0] k);
		logic [7:0] c;
		unique case (k)
			3'd0: c = 8'h75;
			3'd1: c = 8'h73;
			3'd2: c = 8'h74;
			3'd3: c = 8'h61;
			3'd4: c = 8'h72;
			3'd5: c = 8'h20;
			3'd6: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] magic_gnu(input logic [2:0] k);
		logic [7:0] c;
		unique case (k)
			3'd0: c = 8'h47;
			3'd1: c = 8'h4E;
			3'd2: c = 8'h55;
			3'd3: c = 8'h74;
			3'd4: c = 8'h61;
			3'd5: c = 8'h72;
			3'd6: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/thsp_front.sv =====
// ----------------------------------------------------------------------------
// thsp_front
// Header walker: accumulates sums and octal fields, classifies each byte and
// pushes result beats into the queue.
// ----------------------------------------------------------------------------
module thsp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  archive_end,
	output logic                  push,
	output thsp_pkg::result_t     push_data,
	input  logic                  q_full
);

	thsp_pkg::phase_t   phase_q, phase_d;
	logic [8:0]         off_q;
	logic [16:0]        sum_q;
	logic [23:0]        chk_q, own_q, grp_q;
	logic [35:0]        size_q, time_q, left_q;
	logic [7:0]         link_q;
	logic [5:0]         flags_q, flags_d;
	logic [8:0]         pad_q;
	logic               fire, is_oct, last_off;
	logic [35:0]        size_n;
	logic [7:0]         link_n;
	logic [23:0]        chk_n;
	logic [16:0]        sum_n;
	logic [2:0]         mk;
	logic               cs_bad, mg_ok;
	thsp_pkg::result_t  r;
	logic               emit;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;
	assign is_oct   = (in_byte != 8'h00) && (in_byte != 8'h20);
	assign last_off = (off_q == 9'(thsp_pkg::BLOCK_BYTES - 1));
	assign mk       = 3'(off_q - 9'd257);

	// values including the current byte (needed at last offset only for sum)
	assign sum_n = (off_q < 9'd148 || (off_q >= 9'd156 && off_q < 9'd500)) ?
		17'(sum_q + 17'(in_byte)) :
		((off_q < 9'd156) ? 17'(sum_q + 17'h20) : sum_q);
	assign size_n = size_q;
	assign link_n = link_q;
	assign chk_n  = chk_q;

	always_comb begin
		flags_d = flags_q;
		if (in_byte != 8'h00) begin
			flags_d[0] = 1'b0;
			if (off_q == 9'd0)
				flags_d[5] = 1'b0;
		end
		if (off_q >= 9'd257 && off_q < 9'd265) begin
			if (mk < 3'd6) begin
				if (in_byte != ((mk == 3'd5) ? 8'h00 : thsp_pkg::magic_ustar_sp(mk)))
					flags_d[1] = 1'b0;
			end else if (in_byte != 8'h30) begin
				flags_d[2] = 1'b0;
			end
			if (in_byte != thsp_pkg::magic_ustar_sp(mk))
				flags_d[3] = 1'b0;
			if (in_byte != thsp_pkg::magic_gnu(mk))
				flags_d[4] = 1'b0;
		end
	end

	assign cs_bad = (24'(sum_n) != chk_n) && ((chk_n != 24'd0) || flags_d[5]);
	assign mg_ok  = (flags_d[1] && flags_d[2]) || flags_d[3] || flags_d[4];

	always_comb begin
		r       = '0;
		emit    = 1'b0;
		phase_d = phase_q;
		unique case (phase_q)
			thsp_pkg::PH_HEADER: begin
				if (!last_off) begin
					if (archive_end) begin
						emit         = 1'b1;
						r.kind       = thsp_pkg::KIND_ERROR;
						r.error_code = thsp_pkg::ERR_TRUNC;
						phase_d      = thsp_pkg::PH_HALT;
					end
				end else begin
					emit = 1'b1;
					priority if (flags_d[0]) begin
						r.kind  = thsp_pkg::KIND_END;
						phase_d = thsp_pkg::PH_HALT;
					end else if (cs_bad) begin
						r.kind       = thsp_pkg::KIND_ERROR;
						r.error_code = thsp_pkg::ERR_CHECKSUM;
						phase_d      = thsp_pkg::PH_HALT;
					end else if (!mg_ok) begin
						r.kind       = thsp_pkg::KIND_ERROR;
						r.error_code = thsp_pkg::ERR_MAGIC;
						phase_d      = thsp_pkg::PH_HALT;
					end else begin
						r.kind       = thsp_pkg::KIND_HEADER;
						r.entry_size = size_n;
						r.mod_time   = time_q;
						r.owner_num  = own_q;
						r.group_num  = grp_q;
						r.link_type  = link_n;
						r.is_regular = (link_n == 8'h00) || (link_n == 8'h30);
						phase_d = (size_n != 36'd0) ? thsp_pkg::PH_CONTENT :
							thsp_pkg::PH_HEADER;
					end
				end
			end
			thsp_pkg::PH_CONTENT: begin
				emit           = 1'b1;
				r.kind         = thsp_pkg::KIND_CONTENT;
				r.data_byte    = in_byte;
				r.last_of_file = (left_q == 36'd1);
				if (left_q == 36'd1)
					phase_d = (pad_q != 9'd0) ? thsp_pkg::PH_PAD : thsp_pkg::PH_HEADER;
			end
			thsp_pkg::PH_PAD: begin
				if (pad_q <= 9'd1)
					phase_d = thsp_pkg::PH_HEADER;
			end
			default: begin
				phase_d = thsp_pkg::PH_HALT;
			end
		endcase
		if (archive_end)
			phase_d = thsp_pkg::PH_HALT;
	end

	assign push      = fire && emit;
	assign push_data = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= thsp_pkg::PH_HEADER;
			off_q   <= '0;
			sum_q   <= '0;
			chk_q   <= '0;
			own_q   <= '0;
			grp_q   <= '0;
			size_q  <= '0;
			time_q  <= '0;
			link_q  <= '0;
			flags_q <= '1;
			left_q  <= '0;
			pad_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			unique case (phase_q)
				thsp_pkg::PH_HEADER: begin
					if (last_off) begin
						off_q   <= '0;
						sum_q   <= '0;
						chk_q   <= '0;
						own_q   <= '0;
						grp_q   <= '0;
						size_q  <= '0;
						time_q  <= '0;
						link_q  <= '0;
						flags_q <= '1;
						if (phase_d != thsp_pkg::PH_HALT || archive_end) begin
							left_q <= size_q;
							pad_q  <= (size_q[8:0] != 9'd0) ?
								9'(10'(thsp_pkg::BLOCK_BYTES) - 10'(size_q[8:0])) : 9'd0;
						end
					end else begin
						off_q   <= 9'(off_q + 9'd1);
						sum_q   <= sum_n;
						flags_q <= flags_d;
						if (is_oct) begin
							if (off_q >= 9'd108 && off_q < 9'd116)
								own_q <= 24'({own_q, 3'b000} + 27'(in_byte) - 27'h30);
							else if (off_q >= 9'd116 && off_q < 9'd124)
								grp_q <= 24'({grp_q, 3'b000} + 27'(in_byte) - 27'h30);
							else if (off_q >= 9'd124 && off_q < 9'd136)
								size_q <= 36'({size_q, 3'b000} + 39'(in_byte) - 39'h30);
							else if (off_q >= 9'd136 && off_q < 9'd148)
								time_q <= 36'({time_q, 3'b000} + 39'(in_byte) - 39'h30);
							else if (off_q >= 9'd148 && off_q < 9'd156)
								chk_q <= 24'({chk_q, 3'b000} + 27'(in_byte) - 27'h30);
						end
						if (off_q == 9'd156)
							link_q <= in_byte;
					end
				end
				thsp_pkg::PH_CONTENT: begin
					left_q <= 36'(left_q - 36'd1);
				end
				thsp_pkg::PH_PAD: begin
					if (pad_q != 9'd0)
						pad_q <= 9'(pad_q - 9'd1);
				end
				default: begin
					left_q <= left_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/thsp_queue.sv =====
// ----------------------------------------------------------------------------
// thsp_queue
// Two-entry result queue between the header walker and the output stage.
// ----------------------------------------------------------------------------
module thsp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  thsp_pkg::result_t  push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_ready,
	output thsp_pkg::result_t  out_data
);

	thsp_pkg::result_t mem_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= 2'(cnt_q + 2'(push) - 2'(pop));
		end
	end

endmodule

// ===== rtl/core/tar_header_stream_parser_unit.sv =====
// ----------------------------------------------------------------------------
// tar_header_stream_parser_unit
// Streaming ustar header parser: one archive byte per beat in, header, content,
// end and error beats out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle with no bubbles; each byte yields at most one output
// beat, written into a two-entry queue that holds the input off only when the
// output side stalls. After an end, error or truncated header the block
// consumes and drops bytes until reset.
module tar_header_stream_parser_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // in_byte
	input  logic          s_tlast,   // archive_end
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [143:0]  m_tdata,   // error_code, entry_size, mod_time, owner_num,
	                                 // group_num, link_type, is_regular, data_byte, pad
	output logic [1:0]    m_tuser,   // kind
	output logic          m_tlast    // last_of_file
);

	logic              push, full;
	thsp_pkg::result_t pd, od;

	thsp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_byte(s_tdata), .archive_end(s_tlast), .push(push), .push_data(pd),
		.q_full(full)
	);

	thsp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(pd), .full(full),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(od)
	);

	assign m_tuser = od.kind;
	assign m_tlast = od.last_of_file;
	assign m_tdata = {5'd0, od.data_byte, od.is_regular, od.link_type, od.group_num,
		od.owner_num, od.mod_time, od.entry_size, od.error_code};

endmodule

// ===== rtl/core/thsp_checker.sv =====
// ----------------------------------------------------------------------------
// thsp_checker
// Port-level checks of the tar header stream parser.
// ----------------------------------------------------------------------------
`include "tar_header_stream_parser_unit_macros.svh"

module thsp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);

	`THSP_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`THSP_ASSERT_IMP(a_last_content, clk, arst_n, m_tvalid && m_tlast,
		m_tuser == thsp_pkg::KIND_CONTENT)
	`THSP_ASSERT_IMP(a_err_code, clk, arst_n, m_tvalid && m_tuser == thsp_pkg::KIND_ERROR,
		m_tdata[1:0] != thsp_pkg::ERR_NONE)
	`THSP_ASSERT_NEXT(a_ready, clk, arst_n, m_tready, s_tready)

endmodule

bind tar_header_stream_parser_unit thsp_checker u_thsp_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tuser(m_tuser), .m_tlast(m_tlast)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks tar_header_stream_parser_unit against a cycle-free predictor. The
// archive is built as a byte stream: directed headers first (field extremes,
// every magic, checksum corner cases, empty and odd sizes), then random
// entries with random idling on both sides. One terminating event closes the
// archive: zero block, bad checksum, bad magic, truncation or end inside an
// entry. Bytes after the halt are fed to check that nothing more comes out.
// ----------------------------------------------------------------------------
module tb;

	localparam bit [5:0] FL_ZERO = 6'h01, FL_USTAR = 6'h02, FL_VER = 6'h04,
		FL_USTAR_SP = 6'h08, FL_GNU = 6'h10, FL_NAME_EMPTY = 6'h20;
	localparam int MG_USTAR = 0, MG_USTAR_SP = 1, MG_GNU = 2, MG_BAD = 3;
	localparam int SUM_OK = 0, SUM_BLANK = 1, SUM_WRONG = 2;
	localparam int FMT_NUL = 0, FMT_FULL = 1, FMT_SPACE = 2, FMT_JUNK = 3;

	typedef struct {
		bit [35:0] sz;
		bit [35:0] mt;
		bit [23:0] own;
		bit [23:0] grp;
		bit [7:0]  lnk;
		int        mg;
		int        smode;
		bit        nempty;
		int        fmt;
		bit        typed;
	} hrow_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	tar_header_stream_parser_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// parser model state
	thsp_pkg::phase_t ph;
	int        offs;
	bit [16:0] hsum;
	bit [23:0] stored_sum;
	bit [35:0] size_acc, time_acc, left;
	bit [23:0] own_acc, grp_acc;
	bit [7:0]  lnk_b;
	bit [5:0]  flags;
	int        pad;

	thsp_pkg::result_t parsed_q[$];
	hrow_t     row_q[$];
	bit [8:0]  archive_q[$];
	bit [7:0]  hdr[512];
	bit [7:0]  mg_ustar[8] = '{"u", "s", "t", "a", "r", 8'h00, "0", "0"};
	bit [7:0]  mg_ustar_sp[8] = '{"u", "s", "t", "a", "r", " ", " ", 8'h00};
	bit [7:0]  mg_gnu[8] = '{"G", "N", "U", "t", "a", "r", " ", 8'h00};

	int        errors = 0;
	int        cycles = 0;
	int        limit = 2000000;
	bit        calm = 1'b0;
	int        rstall = 0;

	task automatic report(string msg);
		$display("mismatch @%0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic cmp(string name, bit [35:0] got, bit [35:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic bit [35:0] oct_fold(bit [35:0] acc, bit [7:0] b, int bits);
		bit [63:0] v;
		if (b == 8'h00 || b == 8'h20)
			return acc;
		v = ({28'd0, acc} << 3) + 64'(b) - 64'h30;
		return 36'(v & ((64'd1 << bits) - 1));
	endfunction

	function automatic void clear_header();
		offs = 0;
		hsum = '0;
		stored_sum = '0;
		size_acc = '0;
		time_acc = '0;
		own_acc = '0;
		grp_acc = '0;
		lnk_b = '0;
		flags = 6'h3F;
	endfunction

	task automatic parse_byte(bit [7:0] b, bit e);
		thsp_pkg::result_t r;
		hrow_t   t;
		int      o, k;
		if (ph == thsp_pkg::PH_HALT)
			return;
		r = '0;
		if (ph == thsp_pkg::PH_HEADER) begin
			o = offs;
			if (b != 0)
				flags &= ~FL_ZERO;
			if (o == 0 && b != 0)
				flags &= ~FL_NAME_EMPTY;
			if (o < 148 || (o >= 156 && o < 500))
				hsum = 17'(hsum + 17'(b));
			else if (o < 156)
				hsum = 17'(hsum + 17'h20);
			if (o >= 108 && o < 116)
				own_acc = 24'(oct_fold(36'(own_acc), b, 24));
			else if (o >= 116 && o < 124)
				grp_acc = 24'(oct_fold(36'(grp_acc), b, 24));
			else if (o >= 124 && o < 136)
				size_acc = oct_fold(size_acc, b, 36);
			else if (o >= 136 && o < 148)
				time_acc = oct_fold(time_acc, b, 36);
			else if (o >= 148 && o < 156)
				stored_sum = 24'(oct_fold(36'(stored_sum), b, 24));
			else if (o == 156)
				lnk_b = b;
			if (o >= 257 && o < 265) begin
				k = o - 257;
				if (b != mg_ustar[k])
					flags &= (k < 6) ? ~FL_USTAR : ~FL_VER;
				if (b != mg_ustar_sp[k])
					flags &= ~FL_USTAR_SP;
				if (b != mg_gnu[k])
					flags &= ~FL_GNU;
			end
			if (o != thsp_pkg::BLOCK_BYTES - 1) begin
				offs = o + 1;
				if (e) begin
					r.kind = thsp_pkg::KIND_ERROR;
					r.error_code = thsp_pkg::ERR_TRUNC;
					ph = thsp_pkg::PH_HALT;
					parsed_q.push_back(r);
				end
				return;
			end
			if (flags & FL_ZERO) begin
				r.kind = thsp_pkg::KIND_END;
				ph = thsp_pkg::PH_HALT;
			end else if ({19'd0, hsum} != {12'd0, stored_sum} &&
					(stored_sum != 0 || (flags & FL_NAME_EMPTY))) begin
				r.kind = thsp_pkg::KIND_ERROR;
				r.error_code = thsp_pkg::ERR_CHECKSUM;
				ph = thsp_pkg::PH_HALT;
			end else if (!(((flags & FL_USTAR) && (flags & FL_VER)) ||
					(flags & FL_USTAR_SP) || (flags & FL_GNU))) begin
				r.kind = thsp_pkg::KIND_ERROR;
				r.error_code = thsp_pkg::ERR_MAGIC;
				ph = thsp_pkg::PH_HALT;
			end else begin
				r.kind = thsp_pkg::KIND_HEADER;
				r.entry_size = size_acc;
				r.mod_time = time_acc;
				r.owner_num = own_acc;
				r.group_num = grp_acc;
				r.link_type = lnk_b;
				r.is_regular = (lnk_b == 0 || lnk_b == "0");
				left = size_acc;
				pad = (size_acc[8:0] != 0) ? thsp_pkg::BLOCK_BYTES - size_acc[8:0] : 0;
				ph = (left != 0) ? thsp_pkg::PH_CONTENT : thsp_pkg::PH_HEADER;
				if (row_q.size() != 0) begin
					t = row_q.pop_front();
					if (t.typed) begin
						cmp("row size", r.entry_size, t.sz);
						cmp("row mtime", r.mod_time, t.mt);
						cmp("row uid", 36'(r.owner_num), 36'(t.own));
						cmp("row gid", 36'(r.group_num), 36'(t.grp));
						cmp("row link", 36'(r.link_type), 36'(t.lnk));
					end
				end
			end
			clear_header();
			parsed_q.push_back(r);
		end else if (ph == thsp_pkg::PH_CONTENT) begin
			r.kind = thsp_pkg::KIND_CONTENT;
			r.data_byte = b;
			r.last_of_file = (left == 1);
			left = 36'(left - 36'd1);
			if (left == 0)
				ph = (pad != 0) ? thsp_pkg::PH_PAD : thsp_pkg::PH_HEADER;
			parsed_q.push_back(r);
		end else begin
			if (pad > 0)
				pad--;
			if (pad == 0)
				ph = thsp_pkg::PH_HEADER;
		end
		if (e)
			ph = thsp_pkg::PH_HALT;
	endtask

	// ---- archive construction ----
	function automatic void put_oct(int at, int len, bit [35:0] v, int fmt);
		int  n;
		bit  lead;
		n = (fmt == FMT_FULL) ? len : len - 1;
		lead = 1'b1;
		for (int i = 0; i < len; i++) begin
			if (fmt == FMT_JUNK) begin
				hdr[at + i] = 8'($urandom);
			end else if (i < n) begin
				hdr[at + i] = 8'("0" + 8'((v >> (3 * (n - 1 - i))) & 36'd7));
				if (fmt == FMT_SPACE && lead && hdr[at + i] == "0" && i < n - 1)
					hdr[at + i] = " ";
				else
					lead = 1'b0;
			end else begin
				hdr[at + i] = (fmt == FMT_SPACE) ? " " : 8'h00;
			end
		end
	endfunction

	function automatic void make_header(hrow_t h);
		bit [16:0] s;
		int        k;
		foreach (hdr[i])
			hdr[i] = 8'h00;
		if (!h.nempty)
			for (int i = 0; i <= $urandom_range(0, 40); i++)
				hdr[i] = 8'($urandom_range(1, 255));
		put_oct(108, 8, 36'(h.own), h.fmt);
		put_oct(116, 8, 36'(h.grp), h.fmt);
		put_oct(124, 12, h.sz, (h.fmt == FMT_JUNK) ? FMT_NUL : h.fmt);
		put_oct(136, 12, h.mt, h.fmt);
		hdr[156] = h.lnk;
		if (h.fmt == FMT_JUNK) begin
			for (int i = 157; i < 257; i++)
				hdr[i] = 8'($urandom);
			for (int i = 265; i < 500; i++)
				hdr[i] = 8'($urandom);
		end
		for (int i = 500; i < 512; i++)
			hdr[i] = 8'($urandom);
		for (int i = 0; i < 8; i++)
			hdr[257 + i] = (h.mg == MG_USTAR_SP) ? mg_ustar_sp[i] :
				(h.mg == MG_GNU) ? mg_gnu[i] : mg_ustar[i];
		if (h.mg == MG_BAD) begin
			k = 257 + $urandom_range(0, 7);
			hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
		end
		s = '0;
		for (int i = 0; i < 500; i++)
			s = 17'(s + 17'((i >= 148 && i < 156) ? 8'h20 : hdr[i]));
		if (h.smode == SUM_BLANK) begin
			for (int i = 148; i < 156; i++)
				hdr[i] = $urandom_range(0, 1) ? 8'h20 : 8'h00;
		end else begin
			if (h.smode == SUM_WRONG)
				s = 17'(s + 17'd1);
			if (h.fmt == FMT_SPACE)
				put_oct(148, 8, 36'(s), FMT_SPACE);
			else begin
				put_oct(148, 7, 36'(s), FMT_NUL);
				hdr[155] = " ";
			end
		end
	endfunction

	function automatic void push_block(int last_at);
		for (int i = 0; i < 512; i++)
			archive_q.push_back({i == last_at, hdr[i]});
	endfunction

	function automatic void push_body(bit [35:0] sz, longint last_at);
		longint n;
		n = sz + ((sz[8:0] != 0) ? 512 - sz[8:0] : 0);
		for (longint i = 0; i < n; i++)
			archive_q.push_back({i == last_at, 8'($urandom)});
	endfunction

	function automatic void add_entry(hrow_t h);
		make_header(h);
		push_block(-1);
		push_body(h.sz, -1);
	endfunction

	function automatic hrow_t random_row();
		hrow_t h;
		h.sz = ($urandom_range(0, 9) == 0) ? 36'($urandom_range(513, 2000)) :
			36'($urandom_range(0, 520));
		h.mt = 36'({$urandom, $urandom});
		h.own = 24'($urandom);
		h.grp = 24'($urandom);
		h.lnk = ($urandom_range(0, 1) == 0) ? "0" : 8'($urandom);
		h.mg = $urandom_range(MG_USTAR, MG_GNU);
		h.smode = $urandom_range(SUM_OK, SUM_BLANK);
		h.nempty = (h.smode == SUM_OK) && ($urandom_range(0, 7) == 0);
		h.fmt = $urandom_range(FMT_NUL, FMT_JUNK);
		h.typed = 1'b0;
		return h;
	endfunction

	// ---- scoreboard ----
	always @(posedge clk) begin
		thsp_pkg::result_t want;
		if (arst_n) begin
			cycles++;
			if (cycles > limit) begin
				$display("FAILED: results differ");
				$finish;
			end else begin
				if (s_tvalid && s_tready)
					parse_byte(s_tdata, s_tlast);
				if (m_tvalid && m_tready) begin
					if (parsed_q.size() == 0) begin
						report($sformatf("unexpected beat kind %0d", m_tuser));
					end else begin
						want = parsed_q.pop_front();
						cmp("kind", 36'(m_tuser), 36'(want.kind));
						cmp("error_code", 36'(m_tdata[1:0]), 36'(want.error_code));
						cmp("entry_size", m_tdata[37:2], want.entry_size);
						cmp("mod_time", m_tdata[73:38], want.mod_time);
						cmp("owner_num", 36'(m_tdata[97:74]), 36'(want.owner_num));
						cmp("group_num", 36'(m_tdata[121:98]), 36'(want.group_num));
						cmp("link_type", 36'(m_tdata[129:122]), 36'(want.link_type));
						cmp("is_regular", 36'(m_tdata[130]), 36'(want.is_regular));
						cmp("data_byte", 36'(m_tdata[138:131]), 36'(want.data_byte));
						cmp("last_of_file", 36'(m_tlast), 36'(want.last_of_file));
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rstall = 0;
		end else begin
			if (m_tvalid && m_tready)
				rstall = calm ? 0 : $urandom_range(0, 11);
			else if (rstall > 0)
				rstall--;
			m_tready <= (rstall == 0);
		end
	end

	// ---- stimulus ----
	initial begin
		hrow_t dir_rows[8];
		hrow_t h;
		int    pause_at, gap, term, cut;

		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		arst_n = 1'b0;
		ph = thsp_pkg::PH_HEADER;
		left = '0;
		pad = 0;
		clear_header();

		dir_rows = '{
			'{36'd0, 36'd0, 24'd0, 24'd0, 8'h00, MG_USTAR, SUM_OK, 1'b0, FMT_NUL, 1'b1},
			'{36'd1, 36'd1, 24'd1, 24'd1, "0", MG_USTAR_SP, SUM_OK, 1'b0, FMT_NUL, 1'b1},
			'{36'd511, 36'hFFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, "5", MG_GNU, SUM_OK, 1'b0,
				FMT_FULL, 1'b1},
			'{36'd512, 36'd7, 24'd8, 24'd9, 8'hFF, MG_USTAR, SUM_BLANK, 1'b0, FMT_NUL, 1'b1},
			'{36'd513, 36'd64, 24'd100, 24'd200, "0", MG_USTAR, SUM_OK, 1'b1, FMT_NUL, 1'b1},
			'{36'd0, 36'd12345, 24'd0, 24'd77, "1", MG_GNU, SUM_OK, 1'b0, FMT_SPACE, 1'b1},
			'{36'd3, 36'd0, 24'd0, 24'd0, "2", MG_USTAR_SP, SUM_OK, 1'b0, FMT_JUNK, 1'b0},
			'{36'd1000, 36'd99, 24'd4095, 24'd1, "x", MG_USTAR_SP, SUM_BLANK, 1'b0,
				FMT_SPACE, 1'b1}
		};
		foreach (dir_rows[i]) begin
			row_q.push_back(dir_rows[i]);
			add_entry(dir_rows[i]);
		end
		pause_at = archive_q.size();
		while (archive_q.size() < pause_at + 1800)
			add_entry(random_row());

		// closing event
		term = $urandom_range(0, 8);
		h = random_row();
		case (term)
			0: begin
				foreach (hdr[i])
					hdr[i] = 8'h00;
				push_block(511);
			end
			1: begin
				foreach (hdr[i])
					hdr[i] = 8'h00;
				push_block(-1);
			end
			2: begin
				h.smode = SUM_WRONG;
				make_header(h);
				push_block(-1);
			end
			3: begin
				h.smode = SUM_BLANK;
				h.nempty = 1'b1;
				make_header(h);
				push_block(-1);
			end
			4: begin
				h.mg = MG_BAD;
				make_header(h);
				push_block(-1);
			end
			5: begin
				make_header(h);
				push_block($urandom_range(0, 510));
			end
			6: begin
				h.sz = 36'hFFFFFFFFF;
				h.fmt = FMT_FULL;
				make_header(h);
				push_block(-1);
				cut = $urandom_range(0, 300);
				for (int i = 0; i <= cut; i++)
					archive_q.push_back({i == cut, 8'($urandom)});
			end
			7: begin
				h.sz = 36'($urandom_range(1, 500));
				make_header(h);
				push_block(-1);
				push_body(h.sz, h.sz + $urandom_range(0, 511 - h.sz));
			end
			default: begin
				h.sz = 0;
				make_header(h);
				push_block(511);
			end
		endcase
		for (int i = 0; i < 40; i++)
			archive_q.push_back(9'($urandom));
		limit = 100 * archive_q.size() + 100000;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (archive_q[i]) begin
			if ($urandom_range(0, 300) == 0)
				calm = ~calm;
			gap = calm ? 0 : $urandom_range(0, 11);
			if (i == pause_at && gap == 0)
				gap = 1;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
				if (i == pause_at)
					while (parsed_q.size() != 0)
						@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= archive_q[i][7:0];
			s_tlast <= archive_q[i][8];
			do
				@(posedge clk);
			while (!s_tready);
		end
		s_tvalid <= 1'b0;

		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
